FILE: sv/dlr_pkg.sv
// Package for the dense label remapper: defaults, output layout and the
// control word that walks down the cell chain. No dependencies.
package dlr_pkg;

    // Default sizes of the two label tables and of the raw label.
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_LABEL_WIDTH = 32;

    // Result word layout: id, first-seen flag, full flag and count.
    localparam int ID_OUT_W   = 9;
    localparam int OUT_USED_W = 2 * ID_OUT_W + 2;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Table selector values carried on s_tuser.
    localparam logic FUNC_VERTEX = 1'b0;
    localparam logic FUNC_EDGE   = 1'b1;

    // Control bits that travel with a label from cell to cell.
    typedef struct packed {
        logic valid;   // a label occupies this slot of the chain
        logic func;    // table selector
        logic absent;  // the label is the absent marker
        logic done;    // matched or inserted in an earlier cell
        logic first;   // inserted in an earlier cell
    } dlr_ctl_t;

endpackage

FILE: sv/dense_label_remapper.sv
// Top level of the dense label remapper: a chain of key cells and a result stage.
// Depends on dlr_pkg, dlr_cell and dlr_out.
//
// Usage: raw labels enter on the s_ stream, one word per label, with s_tuser
// choosing the vertex table (0) or the edge table (1). Each label walks down a
// chain of TABLE_DEPTH cells, one cell per cycle while the chain moves; cell i
// holds id i of both tables. A label matches the cell holding it, or claims the
// first empty cell of its table, which gives ids in order of first appearance.
// A label past the last cell with neither is an overflow and comes out as -1
// with table_full. The all-ones label passes through as -1 and changes nothing.
// Each word passes the register of every cell and then the output register
// before m_tvalid rises. A new word is accepted every cycle while the chain is
// not held, since a later label always reaches a cell after the labels ahead of
// it have updated that cell.
// When m_tready is low while a result waits, the whole chain holds and
// s_tready drops. Reset empties both tables and the chain, and clears the counts.
module dense_label_remapper #(
    parameter int TABLE_DEPTH = dlr_pkg::DEF_TABLE_DEPTH,
    parameter int LABEL_WIDTH = dlr_pkg::DEF_LABEL_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // label
    input  logic [((LABEL_WIDTH+7)/8)*8-1:0] s_tdata,
    // func
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mapped_label[8:0], first_seen[9], table_full[10], labels_so_far[19:11]
    output logic [dlr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dlr_pkg::*;

    localparam int ID_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

    dlr_ctl_t               stage_ctl [0:TABLE_DEPTH];
    logic [LABEL_WIDTH-1:0] stage_key [0:TABLE_DEPTH];
    logic [ID_W-1:0]        stage_id  [0:TABLE_DEPTH];
    logic                   en;
    logic [LABEL_WIDTH-1:0] in_key;

    // Entry of the chain: a bubble is fed whenever no word is offered.
    assign s_tready = en;
    assign in_key   = s_tdata[LABEL_WIDTH-1:0];

    assign stage_ctl[0] = '{
        valid:  s_tvalid,
        func:   s_tuser,
        absent: (in_key == {LABEL_WIDTH{1'b1}}),
        done:   1'b0,
        first:  1'b0
    };
    assign stage_key[0] = in_key;
    assign stage_id[0]  = '0;

    // The chain of cells.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        dlr_cell #(
            .LABEL_WIDTH(LABEL_WIDTH),
            .ID_W       (ID_W),
            .CELL_IDX   (i)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (en),
            .ctl_i  (stage_ctl[i]),
            .key_i  (stage_key[i]),
            .id_i   (stage_id[i]),
            .ctl_o  (stage_ctl[i+1]),
            .key_o  (stage_key[i+1]),
            .id_o   (stage_id[i+1])
        );
    end

    // Counts, flags and the output register.
    dlr_out #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .ID_W       (ID_W)
    ) u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (stage_ctl[TABLE_DEPTH]),
        .id_i    (stage_id[TABLE_DEPTH]),
        .en      (en),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

FILE: sv/dlr_cell.sv
// One cell of the remapper chain: holds one vertex key and one edge key.
// Depends on dlr_pkg for the control word.
module dlr_cell #(
    parameter int LABEL_WIDTH = 32,
    parameter int ID_W        = 8,
    parameter int CELL_IDX    = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  dlr_pkg::dlr_ctl_t     ctl_i,
    input  logic [LABEL_WIDTH-1:0] key_i,
    input  logic [ID_W-1:0]       id_i,
    output dlr_pkg::dlr_ctl_t     ctl_o,
    output logic [LABEL_WIDTH-1:0] key_o,
    output logic [ID_W-1:0]       id_o
);
    import dlr_pkg::*;

    localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_IDX);

    dlr_ctl_t               ctl_reg, ctl_next;
    logic [LABEL_WIDTH-1:0] key_v_reg, key_e_reg, key_o_reg;
    logic [ID_W-1:0]        id_o_reg, id_next;
    logic                   occ_v_reg, occ_e_reg;
    logic                   sel_occ, active, match, insert;
    logic [LABEL_WIDTH-1:0] sel_key;

    // Compare against the selected table's key, or claim the empty slot.
    always_comb begin
        sel_occ = (ctl_i.func == FUNC_EDGE) ? occ_e_reg : occ_v_reg;
        sel_key = (ctl_i.func == FUNC_EDGE) ? key_e_reg : key_v_reg;
        active  = ctl_i.valid && !ctl_i.absent && !ctl_i.done;
        match   = active && sel_occ && (sel_key == key_i);
        insert  = active && !sel_occ;
        ctl_next = ctl_i;
        id_next  = id_i;
        if (match || insert) begin
            ctl_next.done = 1'b1;
            id_next       = MY_ID;
        end
        if (insert) begin
            ctl_next.first = 1'b1;
        end
    end

    // Control and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg   <= '0;
            occ_v_reg <= 1'b0;
            occ_e_reg <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_next;
            if (insert && ctl_i.func == FUNC_VERTEX) begin
                occ_v_reg <= 1'b1;
            end
            if (insert && ctl_i.func == FUNC_EDGE) begin
                occ_e_reg <= 1'b1;
            end
        end
    end

    // Stored keys and the payload handed to the next cell.
    always_ff @(posedge aclk) begin
        if (en) begin
            key_o_reg <= key_i;
            id_o_reg  <= id_next;
            if (insert && ctl_i.func == FUNC_VERTEX) begin
                key_v_reg <= key_i;
            end
            if (insert && ctl_i.func == FUNC_EDGE) begin
                key_e_reg <= key_i;
            end
        end
    end

    assign ctl_o = ctl_reg;
    assign key_o = key_o_reg;
    assign id_o  = id_o_reg;

endmodule

FILE: sv/dlr_out.sv
// Result stage of the remapper: table counts, flags and the output register.
// Depends on dlr_pkg for the control word and the result layout.
module dlr_out #(
    parameter int TABLE_DEPTH = 256,
    parameter int ID_W        = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dlr_pkg::dlr_ctl_t             ctl_i,
    input  logic [ID_W-1:0]               id_i,
    output logic                          en,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dlr_pkg::OUT_DATA_W-1:0] m_tdata
);
    import dlr_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0]           cnt_v_reg, cnt_v_next, cnt_e_reg, cnt_e_next;
    logic [CNT_W-1:0]           cnt_sel, cnt_new;
    logic [ID_W+ID_OUT_W-1:0]   id_ext;
    logic [CNT_W+ID_OUT_W-1:0]  cnt_ext;
    logic [ID_OUT_W-1:0]        mapped, labels;
    logic                       active, full;
    logic                       m_valid_reg;
    logic [OUT_DATA_W-1:0]      m_data_reg, m_data_next;

    // The whole chain moves whenever the output register can take a word.
    assign en = !m_valid_reg || m_tready;

    // Count after this item, id or -1, and the overflow flag.
    always_comb begin
        cnt_sel    = (ctl_i.func == FUNC_EDGE) ? cnt_e_reg : cnt_v_reg;
        cnt_new    = cnt_sel + CNT_W'(ctl_i.first);
        cnt_v_next = cnt_v_reg;
        cnt_e_next = cnt_e_reg;
        if (ctl_i.valid && ctl_i.func == FUNC_VERTEX) begin
            cnt_v_next = cnt_new;
        end
        if (ctl_i.valid && ctl_i.func == FUNC_EDGE) begin
            cnt_e_next = cnt_new;
        end
        active  = ctl_i.valid && !ctl_i.absent;
        full    = active && !ctl_i.done;
        id_ext  = {{ID_OUT_W{1'b0}}, id_i};
        cnt_ext = {{ID_OUT_W{1'b0}}, cnt_new};
        labels  = cnt_ext[ID_OUT_W-1:0];
        mapped  = (active && ctl_i.done) ? id_ext[ID_OUT_W-1:0] : '1;
        m_data_next = {(OUT_DATA_W - OUT_USED_W)'(0), labels, full, ctl_i.first, mapped};
    end

    // Counts and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_v_reg   <= '0;
            cnt_e_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            cnt_v_reg   <= cnt_v_next;
            cnt_e_reg   <= cnt_e_next;
            m_valid_reg <= ctl_i.valid;
        end
    end

    // Output word.
    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
